[hw/rtl/vqh_pkg.sv]
// Shared types, codes and constants for the voxel quantize and histogram unit.
package vqh_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int GAIN_W     = 32;
    localparam int SIZE_W     = 10;
    localparam int KIND_W     = 2;
    localparam int BIN_W      = 8;
    localparam int BINS       = 256;
    localparam int VALUE_W    = 8;
    localparam int COUNT_W    = 28;
    localparam int ADDR_W     = 27;
    localparam int PROD_W     = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_DIM_DEF     = 512;
    localparam int PAD_ALIGN_DEF   = 4;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [COUNT_W-1:0]  COUNT_MAX       = {COUNT_W{1'b1}};
    localparam logic [VALUE_W-1:0]  VALUE_MAX       = {VALUE_W{1'b1}};
    localparam logic [SAMPLE_W-1:0] LOWER_BOUND_RST = 32'd0;
    localparam logic [GAIN_W-1:0]   GAIN_RST        = 32'd65536;
    localparam logic [SIZE_W-1:0]   SIZE_RST        = 10'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_BOUND = 3'd0,
        CFG_GAIN        = 3'd1,
        CFG_SIZE_X      = 3'd2,
        CFG_SIZE_Y      = 3'd3,
        CFG_SIZE_Z      = 3'd4
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE  = 2'd0,
        KIND_BIN     = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_VOXEL   = 3'd0,
        OP_BIN     = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_OVERRUN = 3'd3,
        OP_NOP     = 3'd4
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic                d_pos;
        logic [SAMPLE_W-1:0] diff;
        logic [BIN_W-1:0]    bin;
        logic                done;
    } t_cls;

endpackage

[hw/rtl/vqh_queue.sv]
// Small first-in first-out queue between the classifying front and the execution back.
module vqh_queue #(
    parameter int W     = 8,
    parameter int DEPTH = vqh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Queue fill count exceeds its depth.");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("Queue popped while empty.");
`endif

endmodule

[hw/rtl/vqh_front.sv]
// Front part: accepts input beats, tracks the volume position and classifies each beat.
module vqh_front #(
    parameter int  MAX_DIM   = vqh_pkg::MAX_DIM_DEF,
    parameter int  PAD_ALIGN = vqh_pkg::PAD_ALIGN_DEF,
    localparam int POS_W     = $clog2(MAX_DIM),
    localparam int PAD_W     = $clog2(MAX_DIM + PAD_ALIGN)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [vqh_pkg::KIND_W-1:0]           i_kind,
    input  logic signed [vqh_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [vqh_pkg::BIN_W-1:0]            i_bin_index,
    input  logic signed [vqh_pkg::SAMPLE_W-1:0]  i_lower_bound,
    input  logic [vqh_pkg::SIZE_W-1:0]           i_size_x,
    input  logic [vqh_pkg::SIZE_W-1:0]           i_size_y,
    input  logic [vqh_pkg::SIZE_W-1:0]           i_size_z,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output vqh_pkg::t_cls                        o_cls,
    output logic [POS_W-1:0]                     o_column,
    output logic [POS_W-1:0]                     o_row,
    output logic [POS_W-1:0]                     o_slice,
    output logic [PAD_W-1:0]                     o_px,
    output logic [PAD_W-1:0]                     o_py
);
    import vqh_pkg::*;

    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int CMP_W     = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;
    localparam int PAD_SH    = PAD_W + $clog2(PAD_ALIGN);
    localparam int PAD_RECIP = ((1 << PAD_SH) + PAD_ALIGN - 1) / PAD_ALIGN;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] n);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(n);
        if (n == '0) begin
            return DIM_W'(1);
        end else if (ext > CMP_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(n);
    endfunction

    // Rounds up to the alignment; the quotient comes from a reciprocal multiply.
    function automatic logic [PAD_W-1:0] pad_dim(input logic [DIM_W-1:0] n);
        logic [PAD_W-1:0]   up;
        logic [2*PAD_W:0]   prod;
        logic [PAD_W-1:0]   quo;
        up   = PAD_W'(n) + PAD_W'(PAD_ALIGN - 1);
        prod = up * (PAD_W + 1)'(PAD_RECIP);
        quo  = PAD_W'(prod >> PAD_SH);
        return PAD_W'(quo * PAD_W'(PAD_ALIGN));
    endfunction

    logic [POS_W-1:0] r_column;
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_slice;
    logic             r_complete;
    logic [POS_W-1:0] n_column;
    logic [POS_W-1:0] n_row;
    logic [POS_W-1:0] n_slice;
    logic             n_complete;

    logic [DIM_W-1:0]    sx;
    logic [DIM_W-1:0]    sy;
    logic [DIM_W-1:0]    sz;
    logic [SAMPLE_W:0]   diff;
    logic [POS_W:0]      col_nx;
    logic [POS_W:0]      row_nx;
    logic [POS_W:0]      slice_nx;
    t_cls                cls;

    assign sx = clamp_dim(i_size_x);
    assign sy = clamp_dim(i_size_y);
    assign sz = clamp_dim(i_size_z);

    assign diff = {i_sample[SAMPLE_W-1], i_sample}
                - {i_lower_bound[SAMPLE_W-1], i_lower_bound};

    assign col_nx   = {1'b0, r_column} + 1'b1;
    assign row_nx   = {1'b0, r_row} + 1'b1;
    assign slice_nx = {1'b0, r_slice} + 1'b1;

    always_comb begin
        n_column   = r_column;
        n_row      = r_row;
        n_slice    = r_slice;
        n_complete = r_complete;
        cls.op     = OP_NOP;
        cls.d_pos  = !diff[SAMPLE_W] && (diff != '0);
        cls.diff   = diff[SAMPLE_W-1:0];
        cls.bin    = i_bin_index;
        cls.done   = 1'b0;
        unique case (t_kind'(i_kind))
            KIND_SAMPLE: begin
                if (r_complete) begin
                    cls.op = OP_OVERRUN;
                end else begin
                    cls.op = OP_VOXEL;
                    if (col_nx >= (POS_W + 1)'(sx)) begin
                        n_column = '0;
                        if (row_nx >= (POS_W + 1)'(sy)) begin
                            n_row = '0;
                            if (slice_nx >= (POS_W + 1)'(sz)) begin
                                n_slice    = '0;
                                n_complete = 1'b1;
                                cls.done   = 1'b1;
                            end else begin
                                n_slice = slice_nx[POS_W-1:0];
                            end
                        end else begin
                            n_row = row_nx[POS_W-1:0];
                        end
                    end else begin
                        n_column = col_nx[POS_W-1:0];
                    end
                end
            end
            KIND_BIN: begin
                cls.op = OP_BIN;
            end
            KIND_RESTART: begin
                cls.op     = OP_CLEAR;
                n_column   = '0;
                n_row      = '0;
                n_slice    = '0;
                n_complete = 1'b0;
            end
            KIND_UNUSED: begin
                cls.op = OP_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column   <= '0;
            r_row      <= '0;
            r_slice    <= '0;
            r_complete <= 1'b0;
        end else if (o_push) begin
            r_column   <= n_column;
            r_row      <= n_row;
            r_slice    <= n_slice;
            r_complete <= n_complete;
        end
    end

    assign o_stall  = i_q_full;
    assign o_push   = i_valid && !i_q_full;
    assign o_cls    = cls;
    assign o_column = r_column;
    assign o_row    = r_row;
    assign o_slice  = r_slice;
    assign o_px     = pad_dim(sx);
    assign o_py     = pad_dim(sy);

`ifndef SYNTHESIS
    a_complete_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_complete) |-> $past(o_push))
        else $error("Volume completion set without an accepted beat.");
`endif

endmodule

[hw/rtl/vqh_back.sv]
// Back part: scales samples, computes padded addresses and keeps the histogram.
module vqh_back #(
    parameter int  MAX_DIM   = vqh_pkg::MAX_DIM_DEF,
    parameter int  PAD_ALIGN = vqh_pkg::PAD_ALIGN_DEF,
    localparam int POS_W     = $clog2(MAX_DIM),
    localparam int PAD_W     = $clog2(MAX_DIM + PAD_ALIGN)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    output logic                            o_pop,
    input  vqh_pkg::t_cls                   i_cls,
    input  logic [POS_W-1:0]                i_column,
    input  logic [POS_W-1:0]                i_row,
    input  logic [POS_W-1:0]                i_slice,
    input  logic [PAD_W-1:0]                i_px,
    input  logic [PAD_W-1:0]                i_py,
    input  logic [vqh_pkg::GAIN_W-1:0]      i_gain,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [vqh_pkg::VALUE_W-1:0]     o_voxel_value,
    output logic [vqh_pkg::ADDR_W-1:0]      o_voxel_address,
    output logic [vqh_pkg::COUNT_W-1:0]     o_bin_count,
    output logic                            o_volume_done,
    output logic                            o_overrun
);
    import vqh_pkg::*;

    localparam int SP_W   = POS_W + PAD_W;
    localparam int LINE_W = SP_W + 1;
    localparam int AP_W   = LINE_W + PAD_W;
    localparam int AX_W   = (AP_W + 1 > ADDR_W) ? AP_W + 1 : ADDR_W;

    typedef struct packed {
        t_op               op;
        logic              d_pos;
        logic [BIN_W-1:0]  bin;
        logic              done;
        logic [PROD_W-1:0] prod;
        logic [SP_W-1:0]   sp;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  column;
        logic [PAD_W-1:0]  px;
    } t_s1;

    typedef struct packed {
        t_op                op;
        logic [BIN_W-1:0]   bin;
        logic               done;
        logic [VALUE_W-1:0] q;
        logic [LINE_W-1:0]  line;
        logic [POS_W-1:0]   column;
        logic [PAD_W-1:0]   px;
    } t_s2;

    typedef struct packed {
        t_op                op;
        logic               done;
        logic [VALUE_W-1:0] q;
        logic [BIN_W-1:0]   rd_addr;
        logic [ADDR_W-1:0]  addr;
    } t_s3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic               done;
        logic               overrun;
    } t_out;

    logic               r_s1_vld;
    logic               r_s2_vld;
    logic               r_s3_vld;
    logic               r_out_vld;
    t_s1                r_s1;
    t_s2                r_s2;
    t_s3                r_s3;
    t_out               r_out;
    t_s1                n_s1;
    t_s2                n_s2;
    t_s3                n_s3;
    t_out               n_out;

    logic [COUNT_W-1:0] r_hist [BINS];
    logic [BINS-1:0]    r_hist_vld;
    logic [COUNT_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic               r_fwd_we;
    logic [BIN_W-1:0]   r_fwd_addr;
    logic [COUNT_W-1:0] r_fwd_data;

    logic               adv;
    logic               clear_now;
    logic               inc;
    logic [BIN_W-1:0]   rd_addr;
    logic [AP_W-1:0]    line_prod;
    logic [AX_W-1:0]    addr_full;
    logic [COUNT_W-1:0] old_count;
    logic [COUNT_W-1:0] new_count;

    assign adv   = !r_out_vld || !i_stall;
    assign o_pop = adv && i_vld;

    always_comb begin
        n_s1.op     = i_cls.op;
        n_s1.d_pos  = i_cls.d_pos;
        n_s1.bin    = i_cls.bin;
        n_s1.done   = i_cls.done;
        n_s1.prod   = i_cls.diff * i_gain;
        n_s1.sp     = i_slice * i_py;
        n_s1.row    = i_row;
        n_s1.column = i_column;
        n_s1.px     = i_px;
    end

    always_comb begin
        n_s2.op     = r_s1.op;
        n_s2.bin    = r_s1.bin;
        n_s2.done   = r_s1.done;
        if (!r_s1.d_pos) begin
            n_s2.q = '0;
        end else if (r_s1.prod[PROD_W-1:40] != '0) begin
            n_s2.q = VALUE_MAX;
        end else begin
            n_s2.q = r_s1.prod[39:32];
        end
        n_s2.line   = LINE_W'(r_s1.sp) + LINE_W'(r_s1.row);
        n_s2.column = r_s1.column;
        n_s2.px     = r_s1.px;
    end

    assign rd_addr   = (r_s2.op == OP_BIN) ? r_s2.bin : r_s2.q;
    assign line_prod = r_s2.line * r_s2.px;
    assign addr_full = AX_W'(line_prod) + AX_W'(r_s2.column);
    assign clear_now = r_s2_vld && (r_s2.op == OP_CLEAR);

    always_comb begin
        n_s3.op      = r_s2.op;
        n_s3.done    = r_s2.done;
        n_s3.q       = r_s2.q;
        n_s3.rd_addr = rd_addr;
        n_s3.addr    = addr_full[ADDR_W-1:0];
    end

    // The bin written on the previous advance has not reached the read data yet.
    always_comb begin
        if (r_fwd_we && (r_fwd_addr == r_s3.rd_addr)) begin
            old_count = r_fwd_data;
        end else if (r_rd_vld) begin
            old_count = r_rd_data;
        end else begin
            old_count = '0;
        end
        new_count = (old_count == COUNT_MAX) ? old_count : old_count + 1'b1;
        inc       = r_s3_vld && (r_s3.op == OP_VOXEL) && (r_s3.q != '0);

        n_out.value   = (r_s3.op == OP_VOXEL) ? r_s3.q : '0;
        n_out.addr    = (r_s3.op == OP_VOXEL) ? r_s3.addr : '0;
        n_out.count   = (r_s3.op == OP_BIN) ? old_count : '0;
        n_out.done    = (r_s3.op == OP_VOXEL) && r_s3.done;
        n_out.overrun = (r_s3.op == OP_OVERRUN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_fwd_we  <= 1'b0;
        end else if (adv) begin
            r_s1_vld  <= i_vld;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= r_s3_vld;
            r_fwd_we  <= inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1       <= n_s1;
            r_s2       <= n_s2;
            r_s3       <= n_s3;
            r_out      <= n_out;
            r_fwd_addr <= r_s3.q;
            r_fwd_data <= new_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_data <= r_hist[rd_addr];
            r_rd_vld  <= r_hist_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && inc) begin
            r_hist[r_s3.q] <= new_count;
        end
    end

    // A restart clears the bins as it enters the read stage; it wins over an older write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_vld <= '0;
        end else if (adv) begin
            if (clear_now) begin
                r_hist_vld <= '0;
            end else if (inc) begin
                r_hist_vld[r_s3.q] <= 1'b1;
            end
        end
    end

    assign o_valid         = r_out_vld;
    assign o_voxel_value   = r_out.value;
    assign o_voxel_address = r_out.addr;
    assign o_bin_count     = r_out.count;
    assign o_volume_done   = r_out.done;
    assign o_overrun       = r_out.overrun;

`ifndef SYNTHESIS
    a_fwd_not_bin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_we |-> (r_fwd_addr != '0))
        else $error("Histogram bin zero was incremented.");
    a_overrun_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.overrun) |-> (r_out.value == '0 && r_out.addr == '0
                                          && r_out.count == '0 && !r_out.done))
        else $error("Overrun beat carries a nonzero field.");
`endif

endmodule

[hw/rtl/voxel_quantize_histogram_unit.sv]
// Top level of the voxel quantize and histogram unit: configuration and block wiring.
//
// Input channel: i_valid with o_stall carries one beat of i_kind, i_sample and
// i_bin_index. Kind 0 quantizes a sample to a byte and gives its padded volume
// address (or flags an overrun once the volume is complete), kind 1 reads one
// histogram bin, kind 2 restarts the volume and clears the histogram, kind 3
// does nothing. Every beat gives one result beat on o_valid with i_stall.
// The unit takes one beat per clock while o_stall is low. Each beat passes the
// four-entry queue and then the pipeline stages behind it (multiply, saturate
// and address sum, histogram read); the histogram read-modify-write goes through
// a one-deep forwarding register and closes one bin update per cycle while the
// receiver does not stall.
// When the receiver stalls, the back pipeline holds and the queue keeps taking
// beats until it is full; o_stall then rises until the output drains.
// Registers are written through i_cfg_we, i_cfg_index and i_cfg_data; the user
// must write them only while the unit is idle, as the unit does not enforce it.
// Reset loads the register defaults, clears the position counters, and empties
// the histogram at once through per-bin valid flags; no clearing pass follows.
module voxel_quantize_histogram_unit #(
    parameter int MAX_DIM     = vqh_pkg::MAX_DIM_DEF,
    parameter int PAD_ALIGN   = vqh_pkg::PAD_ALIGN_DEF,
    parameter int QUEUE_DEPTH = vqh_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [vqh_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [vqh_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [vqh_pkg::BIN_W-1:0]           i_bin_index,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [vqh_pkg::VALUE_W-1:0]         o_voxel_value,
    output logic [vqh_pkg::ADDR_W-1:0]          o_voxel_address,
    output logic [vqh_pkg::COUNT_W-1:0]         o_bin_count,
    output logic                                o_volume_done,
    output logic                                o_overrun,
    input  logic                                i_cfg_we,
    input  logic [vqh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vqh_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import vqh_pkg::*;

    localparam int POS_W = $clog2(MAX_DIM);
    localparam int PAD_W = $clog2(MAX_DIM + PAD_ALIGN);
    localparam int Q_W   = $bits(t_cls) + 3 * POS_W + 2 * PAD_W;

    logic signed [SAMPLE_W-1:0] r_lower_bound;
    logic [GAIN_W-1:0]          r_gain;
    logic [SIZE_W-1:0]          r_size_x;
    logic [SIZE_W-1:0]          r_size_y;
    logic [SIZE_W-1:0]          r_size_z;

    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic             q_full;
    logic [Q_W-1:0]   q_wdata;
    logic [Q_W-1:0]   q_rdata;

    t_cls             f_cls;
    logic [POS_W-1:0] f_column;
    logic [POS_W-1:0] f_row;
    logic [POS_W-1:0] f_slice;
    logic [PAD_W-1:0] f_px;
    logic [PAD_W-1:0] f_py;

    t_cls             b_cls;
    logic [POS_W-1:0] b_column;
    logic [POS_W-1:0] b_row;
    logic [POS_W-1:0] b_slice;
    logic [PAD_W-1:0] b_px;
    logic [PAD_W-1:0] b_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_bound <= LOWER_BOUND_RST;
            r_gain        <= GAIN_RST;
            r_size_x      <= SIZE_RST;
            r_size_y      <= SIZE_RST;
            r_size_z      <= SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LOWER_BOUND: r_lower_bound <= i_cfg_data[SAMPLE_W-1:0];
                CFG_GAIN:        r_gain        <= i_cfg_data[GAIN_W-1:0];
                CFG_SIZE_X:      r_size_x      <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:      r_size_y      <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:      r_size_z      <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    vqh_front #(
        .MAX_DIM   (MAX_DIM),
        .PAD_ALIGN (PAD_ALIGN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_sample      (i_sample),
        .i_bin_index   (i_bin_index),
        .i_lower_bound (r_lower_bound),
        .i_size_x      (r_size_x),
        .i_size_y      (r_size_y),
        .i_size_z      (r_size_z),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cls         (f_cls),
        .o_column      (f_column),
        .o_row         (f_row),
        .o_slice       (f_slice),
        .o_px          (f_px),
        .o_py          (f_py)
    );

    assign q_wdata = {f_cls, f_column, f_row, f_slice, f_px, f_py};

    vqh_queue #(
        .W     (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {b_cls, b_column, b_row, b_slice, b_px, b_py} = q_rdata;

    vqh_back #(
        .MAX_DIM   (MAX_DIM),
        .PAD_ALIGN (PAD_ALIGN)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (!q_empty),
        .o_pop           (q_pop),
        .i_cls           (b_cls),
        .i_column        (b_column),
        .i_row           (b_row),
        .i_slice         (b_slice),
        .i_px            (b_px),
        .i_py            (b_py),
        .i_gain          (r_gain),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_voxel_value   (o_voxel_value),
        .o_voxel_address (o_voxel_address),
        .o_bin_count     (o_bin_count),
        .o_volume_done   (o_volume_done),
        .o_overrun       (o_overrun)
    );

endmodule
